@@ rtl/weia_pkg.sv @@
package weia_pkg;

    // ring select codes
    localparam logic [1:0] RING_ANY   = 2'd0;
    localparam logic [1:0] RING_START = 2'd1;
    localparam logic [1:0] RING_END   = 2'd2;

    localparam int TS_W       = 32;
    localparam int WIN_W      = 16;
    localparam int AVG_W      = 32;
    localparam int DIVIDEND_W = 42;   // 32-bit interval times 1000
    localparam int DIV_STEP_W = 6;

    localparam logic [9:0]  US_PER_MS   = 10'd1000;
    localparam logic [15:0] WINDOW_RST  = 16'd5000;

    typedef struct packed {
        logic load;
        logic push;
        logic rd;
        logic chk;
        logic div_start;
        logic phase;      // 0: shared ring, 1: ring of the item's kind
        logic out_load;
    } weia_cmd_t;

    typedef struct packed {
        logic drop;
        logic div_busy;
        logic out_block;
    } weia_sts_t;

endpackage

@@ rtl/windowed_event_interval_average_core.sv @@
// Windowed event interval average.
// Slave stream: s_tdata carries the event time in ms, s_tuser its kind
// (0 frame started, 1 frame ended). Master stream: one item per input item,
// m_tdata = {avg_kind_us, avg_any_us}, averages of event spacing in us.
// cfg_we/cfg_wdata set the window in ms; write only while the block is idle.
// Each event is pushed into a shared ring and the ring of its kind; stale
// entries are then walked off the oldest end, a read and a check per entry,
// keeping the two newest. One item is processed at a time: per ring a push,
// a read, a check (both again for each dropped entry) and a divide start;
// the shared-ring divide runs while the kind ring is walked, and the
// kind-ring divide (one quotient bit per cycle) sets the tail. s_tready
// returns with m_tvalid. The result sits in an output register; the next
// item is accepted while it waits, and a stalled receiver holds only the
// finish of the following item.
// Reset empties all rings and sets the window to 5000 ms; s_tready is high
// right after reset.
module windowed_event_interval_average_core #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] timestamp_ms
    input  logic        s_tuser,   // [0] event_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] avg_any_us, [63:32] avg_kind_us
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    weia_pkg::weia_cmd_t cmd;
    weia_pkg::weia_sts_t sts;

    weia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    weia_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_ts     (s_tdata),
        .in_kind   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

@@ rtl/weia_div.sv @@
module weia_div #(
    parameter int DIV_W = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [weia_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [DIV_W-1:0]                 divisor,
    output logic                             busy,
    output logic [weia_pkg::DIVIDEND_W-1:0]  quotient
);

    logic                             busy_reg;
    logic [weia_pkg::DIV_STEP_W-1:0]  step_reg;
    logic [weia_pkg::DIVIDEND_W-1:0]  quo_reg;
    logic [DIV_W-1:0]                 rem_reg;
    logic [DIV_W-1:0]                 dvs_reg;

    logic [DIV_W:0]   shifted;
    logic             q_bit;
    logic [DIV_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[weia_pkg::DIVIDEND_W-1]};
        q_bit   = (shifted >= {1'b0, dvs_reg});
        if (q_bit)
        begin
            rem_next = DIV_W'(shifted - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = shifted[DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= weia_pkg::DIV_STEP_W'(weia_pkg::DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == weia_pkg::DIV_STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[weia_pkg::DIVIDEND_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/weia_dp.sv @@
module weia_dp #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  weia_pkg::weia_cmd_t           cmd,
    output weia_pkg::weia_sts_t           sts,
    input  logic [weia_pkg::TS_W-1:0]     in_ts,
    input  logic                          in_kind,
    input  logic                          cfg_we,
    input  logic [weia_pkg::WIN_W-1:0]    cfg_wdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [2*weia_pkg::AVG_W-1:0]  out_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic [weia_pkg::WIN_W-1:0]      window_reg;
    logic [weia_pkg::TS_W-1:0]       now_reg;
    logic                            kind_reg;
    logic [AW-1:0]                   head_reg [0:2];
    logic [CW-1:0]                   count_reg [0:2];
    logic [weia_pkg::TS_W-1:0]       rdata_reg;
    logic [weia_pkg::DIVIDEND_W-1:0] prod_reg;
    logic [1:0]                      one_reg;
    logic                            out_valid_reg;
    logic [2*weia_pkg::AVG_W-1:0]    out_data_reg;

    // three rings share one array, addressed {ring, index}
    logic [weia_pkg::TS_W-1:0] mem [0:(3 << AW)-1];

    logic [1:0]                      sel;
    logic [AW-1:0]                   cur_head;
    logic [CW-1:0]                   cur_count;
    logic [AW-1:0]                   head_inc;
    logic [AW:0]                     tail_sum;
    logic [AW-1:0]                   wr_idx;
    logic [AW-1:0]                   head_next;
    logic [CW-1:0]                   count_next;
    logic                            ring_upd;
    logic [weia_pkg::TS_W-1:0]       age;
    logic                            drop;
    logic [CW-1:0]                   divisor;
    logic                            div_busy0;
    logic                            div_busy1;
    logic [weia_pkg::DIVIDEND_W-1:0] quo0;
    logic [weia_pkg::DIVIDEND_W-1:0] quo1;
    logic [weia_pkg::AVG_W-1:0]      avg0;
    logic [weia_pkg::AVG_W-1:0]      avg1;

    always_comb
    begin
        if (!cmd.phase)
        begin
            sel = weia_pkg::RING_ANY;
        end
        else if (kind_reg)
        begin
            sel = weia_pkg::RING_END;
        end
        else
        begin
            sel = weia_pkg::RING_START;
        end
    end

    assign cur_head  = head_reg[sel];
    assign cur_count = count_reg[sel];
    assign head_inc  = (cur_head == AW'(HISTORY_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign tail_sum  = {1'b0, cur_head} + (AW+1)'(cur_count);
    assign age       = now_reg - rdata_reg;
    assign drop      = (cur_count > CW'(2)) && (age > {16'd0, window_reg});
    assign divisor   = cur_count - CW'(1);

    always_comb
    begin
        if (tail_sum >= (AW+1)'(HISTORY_DEPTH))
        begin
            wr_idx = AW'(tail_sum - (AW+1)'(HISTORY_DEPTH));
        end
        else
        begin
            wr_idx = AW'(tail_sum);
        end
    end

    always_comb
    begin
        head_next  = cur_head;
        count_next = cur_count;
        ring_upd   = 1'b0;
        if (cmd.push)
        begin
            ring_upd = 1'b1;
            if (cur_count < CW'(HISTORY_DEPTH))
            begin
                count_next = cur_count + CW'(1);
            end
            else
            begin
                head_next = head_inc;
            end
        end
        else if (cmd.chk && drop)
        begin
            ring_upd   = 1'b1;
            head_next  = head_inc;
            count_next = cur_count - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= weia_pkg::WINDOW_RST;
            out_valid_reg <= 1'b0;
            one_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (ring_upd)
            begin
                head_reg[sel]  <= head_next;
                count_reg[sel] <= count_next;
            end
            if (cmd.div_start)
            begin
                one_reg[cmd.phase] <= (cur_count == CW'(1));
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= in_ts;
            kind_reg <= in_kind;
        end
        if (cmd.push)
        begin
            mem[{sel, (cur_count < CW'(HISTORY_DEPTH)) ? wr_idx : cur_head}] <= now_reg;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[{sel, cur_head}];
        end
        // newest entry is the item's own time, so the span is the oldest entry's age
        if (cmd.chk && !drop)
        begin
            prod_reg <= weia_pkg::DIVIDEND_W'(age) * weia_pkg::DIVIDEND_W'(weia_pkg::US_PER_MS);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {avg1, avg0};
        end
    end

    weia_div #(
        .DIV_W (CW)
    ) u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start && !cmd.phase),
        .dividend (prod_reg),
        .divisor  (divisor),
        .busy     (div_busy0),
        .quotient (quo0)
    );

    weia_div #(
        .DIV_W (CW)
    ) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start && cmd.phase),
        .dividend (prod_reg),
        .divisor  (divisor),
        .busy     (div_busy1),
        .quotient (quo1)
    );

    // single entry gives zero; saturate above 32 bits
    always_comb
    begin
        if (one_reg[0])
        begin
            avg0 = '0;
        end
        else if (|quo0[weia_pkg::DIVIDEND_W-1:weia_pkg::AVG_W])
        begin
            avg0 = '1;
        end
        else
        begin
            avg0 = quo0[weia_pkg::AVG_W-1:0];
        end
        if (one_reg[1])
        begin
            avg1 = '0;
        end
        else if (|quo1[weia_pkg::DIVIDEND_W-1:weia_pkg::AVG_W])
        begin
            avg1 = '1;
        end
        else
        begin
            avg1 = quo1[weia_pkg::AVG_W-1:0];
        end
    end

    assign sts.drop      = drop;
    assign sts.div_busy  = div_busy0 || div_busy1;
    assign sts.out_block = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/weia_ctrl.sv @@
module weia_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output weia_pkg::weia_cmd_t  cmd,
    input  weia_pkg::weia_sts_t  sts
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PUSH  = 6'b000010,
        ST_RD    = 6'b000100,
        ST_CHK   = 6'b001000,
        ST_DIVGO = 6'b010000,
        ST_WAIT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   phase_reg;
    logic   phase_next;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd           = '0;
        cmd.phase     = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // stale oldest entry: drop it and look at the next one
                cmd.chk    = 1'b1;
                state_next = sts.drop ? ST_RD : ST_DIVGO;
            end
            ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    state_next = ST_PUSH;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!sts.div_busy && !sts.out_block)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

@@ rtl/weia_chk.sv @@
module weia_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared with no item in work");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
        else $error("block went idle without presenting a result");

endmodule

bind windowed_event_interval_average_core weia_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
